FILE: hdl/bscp_pkg.sv
// shared types, constants and the normal magnitude table for the box surface closest point block
`timescale 1ns / 1ps
`default_nettype none
package bscp_pkg;

   localparam int DIMENSIONS_DEF   = 3;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int MAX_AXES         = 3;
   localparam int NORMAL_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int COUNT_WIDTH      = 2;
   localparam int UPPER_RESET      = 256;

   localparam logic [NORMAL_WIDTH-1:0] MAG_ONE   = 16'd16384;
   localparam logic [NORMAL_WIDTH-1:0] MAG_TWO   = 16'd11585;
   localparam logic [NORMAL_WIDTH-1:0] MAG_THREE = 16'd9459;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_LOWER_X = 3'd0,
      REG_LOWER_Y = 3'd1,
      REG_LOWER_Z = 3'd2,
      REG_UPPER_X = 3'd3,
      REG_UPPER_Y = 3'd4,
      REG_UPPER_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic snap;
      logic square;
   } stage_en_type;

   typedef struct packed {
      logic interior;
      logic upper;
   } axis_flags_type;

   // unit length scale by number of snapped axes
   function automatic logic [NORMAL_WIDTH-1:0] unit_mag(input logic [COUNT_WIDTH-1:0] k);
      logic [NORMAL_WIDTH-1:0] mag;
      case (k)
         2'd1: begin
            mag = MAG_ONE;
         end
         2'd2: begin
            mag = MAG_TWO;
         end
         2'd3: begin
            mag = MAG_THREE;
         end
         default: begin
            mag = '0;
         end
      endcase
      return mag;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/box_surface_closest_point.sv
// top level: box corner registers, input register, axis pipelines and result register
//
//   channel   direction  handshake                payload
//   req_      in         req_valid / req_stall    req_point_x/y/z
//   rsp_      out        rsp_valid / rsp_stall    rsp_near_x/y/z, rsp_normal_x/y/z
//   csr_      in         csr_write_en             csr_index, csr_data
//
// one item per cycle while the result side does not stall; an accepted item passes
// through the input register, snap stage, squaring stage and result register in
// that order; the squaring multiplier of each axis sets the stage depth
// reset is synchronous and clears the valid bits and loads the default unit box
// each stage moves on whenever the stage after it is empty or moving, so a stalled
// result holds only the stages that are full behind it
`timescale 1ns / 1ps
`default_nettype none
module box_surface_closest_point #(
   parameter int DIMENSIONS  = bscp_pkg::DIMENSIONS_DEF,
   parameter int COORD_WIDTH = bscp_pkg::COORD_WIDTH_DEF
) (
   input  wire                                           clock,
   input  wire                                           reset,
   input  wire                                           req_valid,
   output logic                                          req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]            req_point_x,
   input  wire logic signed [COORD_WIDTH-1:0]            req_point_y,
   input  wire logic signed [COORD_WIDTH-1:0]            req_point_z,
   output logic                                          rsp_valid,
   input  wire                                           rsp_stall,
   output logic signed [COORD_WIDTH-1:0]                 rsp_near_x,
   output logic signed [COORD_WIDTH-1:0]                 rsp_near_y,
   output logic signed [COORD_WIDTH-1:0]                 rsp_near_z,
   output logic signed [bscp_pkg::NORMAL_WIDTH-1:0]      rsp_normal_x,
   output logic signed [bscp_pkg::NORMAL_WIDTH-1:0]      rsp_normal_y,
   output logic signed [bscp_pkg::NORMAL_WIDTH-1:0]      rsp_normal_z,
   input  wire                                           csr_write_en,
   input  wire logic [bscp_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [COORD_WIDTH-1:0]                   csr_data
);

   localparam int AXES = bscp_pkg::MAX_AXES;

   logic signed [COORD_WIDTH-1:0] lower_in [AXES];
   logic signed [COORD_WIDTH-1:0] lower_ff [AXES];
   logic signed [COORD_WIDTH-1:0] upper_in [AXES];
   logic signed [COORD_WIDTH-1:0] upper_ff [AXES];

   logic signed [COORD_WIDTH-1:0] req_point [AXES];
   logic signed [COORD_WIDTH-1:0] point_ff  [AXES];

   logic v0_in, v0_ff, v1_in, v1_ff, v2_in, v2_ff, out_in, out_ff;
   logic ready0, ready1, ready2, out_ready;
   logic load0, load_out;
   bscp_pkg::stage_en_type stage_en;

   logic [2*COORD_WIDTH-1:0]          axis_sq    [AXES];
   logic signed [COORD_WIDTH-1:0]     axis_snap  [AXES];
   logic signed [COORD_WIDTH-1:0]     axis_point [AXES];
   bscp_pkg::axis_flags_type          axis_flags [AXES];
   logic signed [COORD_WIDTH-1:0]     near       [AXES];
   logic signed [bscp_pkg::NORMAL_WIDTH-1:0] normal [AXES];

   // box corner registers
   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      if (csr_write_en) begin
         case (bscp_pkg::csr_index_type'(csr_index))
            bscp_pkg::REG_LOWER_X: begin
               lower_in[0] = csr_data;
            end
            bscp_pkg::REG_LOWER_Y: begin
               lower_in[1] = csr_data;
            end
            bscp_pkg::REG_LOWER_Z: begin
               lower_in[2] = csr_data;
            end
            bscp_pkg::REG_UPPER_X: begin
               upper_in[0] = csr_data;
            end
            bscp_pkg::REG_UPPER_Y: begin
               upper_in[1] = csr_data;
            end
            bscp_pkg::REG_UPPER_Z: begin
               upper_in[2] = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   always_comb begin
      out_ready = !out_ff || !rsp_stall;
      ready2    = !v2_ff || out_ready;
      ready1    = !v1_ff || ready2;
      ready0    = !v0_ff || ready1;
      load0     = ready0 && req_valid;
      stage_en.snap   = ready1 && v0_ff;
      stage_en.square = ready2 && v1_ff;
      load_out  = out_ready && v2_ff;
      v0_in     = ready0 ? req_valid : v0_ff;
      v1_in     = ready1 ? v0_ff : v1_ff;
      v2_in     = ready2 ? v1_ff : v2_ff;
      out_in    = out_ready ? v2_ff : out_ff;
   end

   assign req_point[0] = req_point_x;
   assign req_point[1] = req_point_y;
   assign req_point[2] = req_point_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            lower_ff[i] <= '0;
            upper_ff[i] <= COORD_WIDTH'(bscp_pkg::UPPER_RESET);
         end
         v0_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         v0_ff    <= v0_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         out_ff   <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load0) begin
         point_ff <= req_point;
      end
   end

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      if (a < DIMENSIONS) begin : g_used
         bscp_axis #(
            .COORD_WIDTH (COORD_WIDTH)
         ) u_axis (
            .clock     (clock),
            .en        (stage_en),
            .point     (point_ff[a]),
            .lower     (lower_ff[a]),
            .upper     (upper_ff[a]),
            .sq        (axis_sq[a]),
            .snap      (axis_snap[a]),
            .point_out (axis_point[a]),
            .flags     (axis_flags[a])
         );
      end else begin : g_unused
         assign axis_sq[a]    = '0;
         assign axis_snap[a]  = '0;
         assign axis_point[a] = '0;
         assign axis_flags[a] = '0;
      end
   end

   bscp_select #(
      .DIMENSIONS  (DIMENSIONS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_select (
      .clock  (clock),
      .load   (load_out),
      .sq     (axis_sq),
      .snap   (axis_snap),
      .point  (axis_point),
      .flags  (axis_flags),
      .near   (near),
      .normal (normal)
   );

   assign req_stall    = !ready0;
   assign rsp_valid    = out_ff;
   assign rsp_near_x   = near[0];
   assign rsp_near_y   = near[1];
   assign rsp_near_z   = near[2];
   assign rsp_normal_x = normal[0];
   assign rsp_normal_y = normal[1];
   assign rsp_normal_z = normal[2];

   // at least one axis is always snapped
   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x != '0 || rsp_normal_y != '0 || rsp_normal_z != '0))
      else $error("result item without a snapped axis");

   // the input side only stalls when the input register is full and cannot move
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v0_ff && v1_ff && v2_ff && out_ff))
      else $error("input stalled with room in the pipeline");

   // a blocked item in the squaring stage stays put
   a_hold_square: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready2) |=> v2_ff)
      else $error("item lost from squaring stage");

   // a new result only follows an item in the squaring stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v2_ff))
      else $error("result item without a source");

endmodule
`default_nettype wire

FILE: hdl/bscp_axis.sv
// per-axis face snap and squared distance, two pipeline stages
`timescale 1ns / 1ps
`default_nettype none
module bscp_axis #(
   parameter int COORD_WIDTH = bscp_pkg::COORD_WIDTH_DEF
) (
   input  wire                                clock,
   input  bscp_pkg::stage_en_type             en,
   input  wire logic signed [COORD_WIDTH-1:0] point,
   input  wire logic signed [COORD_WIDTH-1:0] lower,
   input  wire logic signed [COORD_WIDTH-1:0] upper,
   output logic [2*COORD_WIDTH-1:0]           sq,
   output logic signed [COORD_WIDTH-1:0]      snap,
   output logic signed [COORD_WIDTH-1:0]      point_out,
   output bscp_pkg::axis_flags_type           flags
);

   logic signed [COORD_WIDTH:0]   diff_lo;
   logic signed [COORD_WIDTH:0]   diff_hi;
   logic [COORD_WIDTH:0]          abs_lo;
   logic [COORD_WIDTH:0]          abs_hi;
   logic [COORD_WIDTH-1:0]        dist_lo;
   logic [COORD_WIDTH-1:0]        dist_hi;

   logic [COORD_WIDTH-1:0]        dist_in,  dist_ff;
   logic signed [COORD_WIDTH-1:0] snap_in,  snap1_ff, snap2_ff;
   logic signed [COORD_WIDTH-1:0] point1_ff, point2_ff;
   bscp_pkg::axis_flags_type      flags_in, flags1_ff, flags2_ff;
   logic [2*COORD_WIDTH-1:0]      sq_in,    sq_ff;

   always_comb begin
      diff_lo = {point[COORD_WIDTH-1], point} - {lower[COORD_WIDTH-1], lower};
      diff_hi = {point[COORD_WIDTH-1], point} - {upper[COORD_WIDTH-1], upper};
      abs_lo  = diff_lo[COORD_WIDTH] ? (~diff_lo + 1'b1) : diff_lo;
      abs_hi  = diff_hi[COORD_WIDTH] ? (~diff_hi + 1'b1) : diff_hi;
      dist_lo = abs_lo[COORD_WIDTH-1:0];
      dist_hi = abs_hi[COORD_WIDTH-1:0];
      // tie goes to the upper face
      flags_in.upper    = !(dist_lo < dist_hi);
      flags_in.interior = (point > lower) && (point < upper);
      dist_in = flags_in.upper ? dist_hi : dist_lo;
      snap_in = flags_in.upper ? upper : lower;
      sq_in   = dist_ff * dist_ff;
   end

   always_ff @(posedge clock) begin
      if (en.snap) begin
         dist_ff   <= dist_in;
         snap1_ff  <= snap_in;
         point1_ff <= point;
         flags1_ff <= flags_in;
      end
      if (en.square) begin
         sq_ff     <= sq_in;
         snap2_ff  <= snap1_ff;
         point2_ff <= point1_ff;
         flags2_ff <= flags1_ff;
      end
   end

   assign sq        = sq_ff;
   assign snap      = snap2_ff;
   assign point_out = point2_ff;
   assign flags     = flags2_ff;

endmodule
`default_nettype wire

FILE: hdl/bscp_select.sv
// picks the dropped axis, builds the surface point and unit normal, result register
`timescale 1ns / 1ps
`default_nettype none
module bscp_select #(
   parameter int DIMENSIONS  = bscp_pkg::DIMENSIONS_DEF,
   parameter int COORD_WIDTH = bscp_pkg::COORD_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                load,
   input  wire logic [2*COORD_WIDTH-1:0]      sq        [bscp_pkg::MAX_AXES],
   input  wire logic signed [COORD_WIDTH-1:0] snap      [bscp_pkg::MAX_AXES],
   input  wire logic signed [COORD_WIDTH-1:0] point     [bscp_pkg::MAX_AXES],
   input  bscp_pkg::axis_flags_type           flags     [bscp_pkg::MAX_AXES],
   output logic signed [COORD_WIDTH-1:0]      near      [bscp_pkg::MAX_AXES],
   output logic signed [bscp_pkg::NORMAL_WIDTH-1:0] normal [bscp_pkg::MAX_AXES]
);

   localparam int AXIS_W = $clog2(DIMENSIONS);

   logic                                all_inside;
   logic [AXIS_W-1:0]                   drop;
   logic [2*COORD_WIDTH-1:0]            best_sq;
   logic [bscp_pkg::MAX_AXES-1:0]       snapped;
   logic [bscp_pkg::COUNT_WIDTH-1:0]    k;
   logic [bscp_pkg::NORMAL_WIDTH-1:0]   mag;

   logic signed [COORD_WIDTH-1:0]            near_in   [bscp_pkg::MAX_AXES];
   logic signed [COORD_WIDTH-1:0]            near_ff   [bscp_pkg::MAX_AXES];
   logic signed [bscp_pkg::NORMAL_WIDTH-1:0] normal_in [bscp_pkg::MAX_AXES];
   logic signed [bscp_pkg::NORMAL_WIDTH-1:0] normal_ff [bscp_pkg::MAX_AXES];

   always_comb begin
      all_inside = 1'b1;
      for (int i = 0; i < DIMENSIONS; i++) begin
         all_inside = all_inside && flags[i].interior;
      end
      // with every slab inside, snap the axis of least distance; a tie prefers the higher axis
      drop    = '0;
      best_sq = sq[0];
      for (int j = 1; j < DIMENSIONS; j++) begin
         if (sq[j] <= best_sq) begin
            drop    = AXIS_W'(j);
            best_sq = sq[j];
         end
      end
      k = '0;
      for (int i = 0; i < bscp_pkg::MAX_AXES; i++) begin
         if (i < DIMENSIONS) begin
            snapped[i] = !flags[i].interior || (all_inside && (drop == AXIS_W'(i)));
         end else begin
            snapped[i] = 1'b0;
         end
         k = k + bscp_pkg::COUNT_WIDTH'(snapped[i]);
      end
      mag = bscp_pkg::unit_mag(k);
      for (int i = 0; i < bscp_pkg::MAX_AXES; i++) begin
         if (i >= DIMENSIONS) begin
            near_in[i]   = '0;
            normal_in[i] = '0;
         end else if (snapped[i]) begin
            near_in[i]   = snap[i];
            normal_in[i] = flags[i].upper ? mag : (~mag + 1'b1);
         end else begin
            near_in[i]   = point[i];
            normal_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         near_ff   <= near_in;
         normal_ff <= normal_in;
      end
   end

   assign near   = near_ff;
   assign normal = normal_ff;

endmodule
`default_nettype wire

FILE: bench/tb_box_surface_closest_point.sv
// testbench for box_surface_closest_point: directed and random points against a predicting model
`timescale 1ns / 1ps
module tb_box_surface_closest_point;

   localparam logic [bscp_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
   localparam logic [bscp_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;
   localparam int LONG_HOLD = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT = 20000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 110;
   localparam int PRESSURE_ITEMS = 60;
   localparam logic [bscp_pkg::NORMAL_WIDTH-1:0] UNIT_SCALE [4] =
      '{16'd0, bscp_pkg::MAG_ONE, bscp_pkg::MAG_TWO, bscp_pkg::MAG_THREE};

   typedef struct packed {
      logic [15:0] near_x;
      logic [15:0] near_y;
      logic [15:0] near_z;
      logic [15:0] normal_x;
      logic [15:0] normal_y;
      logic [15:0] normal_z;
   } surface_point_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_point_x = '0;
   logic [15:0] req_point_y = '0;
   logic [15:0] req_point_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_near_x;
   logic signed [15:0] rsp_near_y;
   logic signed [15:0] rsp_near_z;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic csr_write_en = 1'b0;
   logic [bscp_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   logic signed [15:0] box_lower [3];
   logic signed [15:0] box_upper [3];
   surface_point_type expected_surface [$];
   int mismatch_count = 0;

   int burst_left = 0;
   bit sender_paced = 1'b1;

   bit hold_req = 1'b0;
   bit hold_ack = 1'b0;
   int hold_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;
   int pattern_count = 0;

   box_surface_closest_point dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_near_x   (rsp_near_x),
      .rsp_near_y   (rsp_near_y),
      .rsp_near_z   (rsp_near_z),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("box_surface_closest_point: mismatch");
      $finish;
   end

   // nearest surface point over all subsets of kept axes but the one that keeps every axis
   function automatic surface_point_type closest_on_surface(input logic signed [15:0] px,
                                                            input logic signed [15:0] py,
                                                            input logic signed [15:0] pz);
      longint p [3];
      longint lo [3];
      longint hi [3];
      longint pt [3];
      longint best_pt [3];
      int nrm [3];
      int best_nrm [3];
      longint unsigned sum_sq, best_dist, dl, du;
      int k, best_k, s, i;
      bit ok, have;
      logic [15:0] mag;
      logic [15:0] nv [3];
      surface_point_type r;
      p[0] = longint'(px);
      p[1] = longint'(py);
      p[2] = longint'(pz);
      have = 1'b0;
      best_dist = 0;
      best_k = 0;
      for (i = 0; i < 3; i++) begin
         lo[i] = longint'(box_lower[i]);
         hi[i] = longint'(box_upper[i]);
         best_pt[i] = 0;
         best_nrm[i] = 0;
      end
      for (s = 0; s < 7; s++) begin
         ok = 1'b1;
         sum_sq = 0;
         k = 0;
         for (i = 0; i < 3; i++) begin
            pt[i] = 0;
            nrm[i] = 0;
         end
         for (i = 0; i < 3; i++) begin
            if (ok) begin
               if ((s >> i) & 1) begin
                  if (p[i] <= lo[i] || p[i] >= hi[i]) begin
                     ok = 1'b0;
                  end else begin
                     pt[i] = p[i];
                  end
               end else begin
                  dl = (p[i] >= lo[i]) ? p[i] - lo[i] : lo[i] - p[i];
                  du = (p[i] >= hi[i]) ? p[i] - hi[i] : hi[i] - p[i];
                  if (dl < du) begin
                     sum_sq += dl * dl;
                     pt[i] = lo[i];
                     nrm[i] = -1;
                  end else begin
                     sum_sq += du * du;
                     pt[i] = hi[i];
                     nrm[i] = 1;
                  end
                  k++;
               end
            end
         end
         if (ok && (!have || sum_sq < best_dist)) begin
            have = 1'b1;
            best_dist = sum_sq;
            best_k = k;
            for (i = 0; i < 3; i++) begin
               best_pt[i] = pt[i];
               best_nrm[i] = nrm[i];
            end
         end
      end
      mag = UNIT_SCALE[best_k & 3];
      for (i = 0; i < 3; i++) begin
         if (best_nrm[i] > 0) begin
            nv[i] = mag;
         end else if (best_nrm[i] < 0) begin
            nv[i] = -mag;
         end else begin
            nv[i] = '0;
         end
      end
      r.near_x = best_pt[0][15:0];
      r.near_y = best_pt[1][15:0];
      r.near_z = best_pt[2][15:0];
      r.normal_x = nv[0];
      r.normal_y = nv[1];
      r.normal_z = nv[2];
      return r;
   endfunction

   // coordinate biased toward faces, slab interior and midpoint ties
   function automatic logic [15:0] pick_coord(input int lo, input int hi);
      int a, b, v;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 9))
         0: begin
            v = lo;
         end
         1: begin
            v = hi;
         end
         2: begin
            v = lo + 1;
         end
         3: begin
            v = hi - 1;
         end
         4: begin
            v = (lo + hi) >>> 1;
         end
         5: begin
            v = $urandom_range(0, 65535) - 32768;
         end
         6: begin
            v = a - $urandom_range(0, 300);
         end
         7: begin
            v = b + $urandom_range(0, 300);
         end
         default: begin
            v = a + $urandom_range(0, b - a);
         end
      endcase
      return v[15:0];
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t %s expected %0d actual %0d", $time, name, $signed(want), $signed(got));
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      surface_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_surface.size() == 0) begin
            $display("%0t unexpected result expected none actual near %0d %0d %0d",
                     $time, rsp_near_x, rsp_near_y, rsp_near_z);
            mismatch_count++;
         end else begin
            want = expected_surface.pop_front();
            compare_field("near_x", want.near_x, rsp_near_x);
            compare_field("near_y", want.near_y, rsp_near_y);
            compare_field("near_z", want.near_z, rsp_near_z);
            compare_field("normal_x", want.normal_x, rsp_normal_x);
            compare_field("normal_y", want.normal_y, rsp_normal_y);
            compare_field("normal_z", want.normal_z, rsp_normal_z);
         end
      end
   end

   always @(posedge clock) begin : receiver_pattern
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         pattern_count <= pattern_count + 1;
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(8, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_LIGHT: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= (pattern_count % 5) < 2;
            end
         endcase
      end
   end

   task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      int gap;
      if (burst_left == 0) begin
         gap = 0;
         if (sender_paced && $urandom_range(0, 2) != 0) begin
            gap = $urandom_range(1, 8);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_surface.push_back(closest_on_surface(x, y, z));
      burst_left--;
   endtask

   task automatic send_random_point();
      send_point(pick_coord(box_lower[0], box_upper[0]),
                 pick_coord(box_lower[1], box_upper[1]),
                 pick_coord(box_lower[2], box_upper[2]));
   endtask

   task automatic write_reg(input logic [bscp_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         bscp_pkg::REG_LOWER_X: box_lower[0] = value;
         bscp_pkg::REG_LOWER_Y: box_lower[1] = value;
         bscp_pkg::REG_LOWER_Z: box_lower[2] = value;
         bscp_pkg::REG_UPPER_X: box_upper[0] = value;
         bscp_pkg::REG_UPPER_Y: box_upper[1] = value;
         bscp_pkg::REG_UPPER_Z: box_upper[2] = value;
         default: ;
      endcase
   endtask

   // waits for the pipeline to empty, then loads both corners and pokes the unused indexes
   task automatic load_box(input int lx, input int ly, input int lz,
                           input int ux, input int uy, input int uz);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_surface.size() != 0) @(posedge clock);
      write_reg(bscp_pkg::REG_LOWER_X, lx[15:0]);
      write_reg(bscp_pkg::REG_LOWER_Y, ly[15:0]);
      write_reg(bscp_pkg::REG_LOWER_Z, lz[15:0]);
      write_reg(bscp_pkg::REG_UPPER_X, ux[15:0]);
      write_reg(bscp_pkg::REG_UPPER_Y, uy[15:0]);
      write_reg(bscp_pkg::REG_UPPER_Z, uz[15:0]);
      write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
      write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
      csr_write_en <= 1'b0;
   endtask

   task automatic random_box();
      int lo [3];
      int hi [3];
      int mode, cube, width, odd_axis, i;
      mode = $urandom_range(0, 5);
      cube = 2 * $urandom_range(1, 1500);
      odd_axis = $urandom_range(0, 2);
      for (i = 0; i < 3; i++) begin
         case (mode)
            0: begin
               width = $urandom_range(1, 3000);
               lo[i] = $urandom_range(0, 65535 - width) - 32768;
               hi[i] = lo[i] + width;
            end
            1: begin
               lo[i] = $urandom_range(0, 65535 - cube) - 32768;
               hi[i] = lo[i] + cube;
            end
            2: begin
               width = $urandom_range(1, 4);
               lo[i] = $urandom_range(0, 65535 - width) - 32768;
               hi[i] = lo[i] + width;
            end
            3: begin
               lo[i] = $urandom_range(0, 65535) - 32768;
               hi[i] = $urandom_range(0, 65535) - 32768;
            end
            4: begin
               lo[i] = ($urandom_range(0, 3) == 0) ? 32767 : -32768;
               hi[i] = ($urandom_range(0, 3) == 0) ? -32768 : 32767;
            end
            default: begin
               width = $urandom_range(1, 3000);
               lo[i] = $urandom_range(0, 65535 - width) - 32768;
               hi[i] = lo[i] + width;
               if (i == odd_axis) begin
                  hi[i] = $urandom_range(0, 1) ? lo[i] : lo[i] - $urandom_range(1, 2000);
               end
            end
         endcase
      end
      load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endtask

   // default unit box straight out of reset, including ties between faces and subsets
   task automatic test_reset_box();
      send_point(16'd128, 16'd128, 16'd128);
      send_point(16'd64, 16'd128, 16'd200);
      send_point(-16'sd100, 16'd300, 16'd128);
      send_point(16'd0, 16'd0, 16'd0);
      send_point(16'd256, 16'd256, 16'd256);
      send_point(16'h8000, 16'h8000, 16'h8000);
      send_point(16'h7fff, 16'h7fff, 16'h7fff);
      send_point(16'd1, 16'd255, 16'd128);
      send_point(16'h8000, 16'h7fff, 16'd0);
   endtask

   // full range box, so snapped distances reach their widest
   task automatic test_wide_box();
      load_box(-32768, -32768, -32768, 32767, 32767, 32767);
      send_point(16'd0, 16'd0, 16'd0);
      send_point(16'h8001, 16'h7ffe, 16'd5);
      send_point(16'h7fff, 16'h8000, 16'd100);
      send_point(16'hffff, 16'd0, 16'd1);
   endtask

   // inverted x, flat y, then a cube centered on the origin for equal distances
   task automatic test_odd_boxes();
      load_box(1000, 50, -256, -1000, 50, 512);
      send_point(16'd0, 16'd50, 16'd0);
      send_point(16'd1000, -16'sd1000, 16'd512);
      send_point(-16'sd5, 16'd77, -16'sd300);
      send_point(16'd0, 16'd0, 16'd128);
      load_box(-512, -512, -512, 512, 512, 512);
      send_point(16'd0, 16'd0, 16'd0);
      send_point(16'd300, 16'd300, 16'd0);
      send_point(-16'sd300, 16'd300, -16'sd300);
   endtask

   task automatic test_random_boxes();
      int phase, n;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_box();
         sender_paced = ($urandom_range(0, 3) != 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_random_point();
         end
      end
      sender_paced = 1'b1;
   endtask

   // long receiver hold while the sender keeps offering items
   task automatic test_back_pressure();
      int n;
      random_box();
      sender_paced = 1'b0;
      hold_req <= ~hold_req;
      for (n = 0; n < PRESSURE_ITEMS; n++) begin
         send_random_point();
      end
      sender_paced = 1'b1;
   endtask

   initial begin : run_tests
      int waited;
      for (int i = 0; i < 3; i++) begin
         box_lower[i] = '0;
         box_upper[i] = 16'(bscp_pkg::UPPER_RESET);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_box();
      test_wide_box();
      test_odd_boxes();
      test_random_boxes();
      test_back_pressure();
      req_valid <= 1'b0;
      waited = 0;
      while (expected_surface.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_surface.size() != 0) begin
         $display("%0t missing results expected %0d actual 0", $time, expected_surface.size());
         mismatch_count += expected_surface.size();
      end
      if (mismatch_count == 0) begin
         $display("box_surface_closest_point: match");
      end else begin
         $display("box_surface_closest_point: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/bscp_pkg.sv
hdl/bscp_axis.sv
hdl/bscp_select.sv
hdl/box_surface_closest_point.sv
bench/tb_box_surface_closest_point.sv
